// File: sv/ffkds_pkg.sv
package ffkds_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 49;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ECNT_W   = 9;

  typedef logic [1:0]        mode_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_QUERY  = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // search token moving down the cell row
  typedef struct packed {
    logic valid;
    key_t key;
    logic hit;
  } probe_t;

  typedef struct packed {
    logic              hit;
    logic              stored;
    logic              dropped_full;
    logic [ECNT_W-1:0] entry_count;
  } result_t;

endpackage

// File: sv/ffkds_in_if.sv
interface ffkds_in_if import ffkds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] map_number;
  logic signed [15:0] level_number;
  logic               dynamic_flag;
  logic signed [15:0] item_index;

  modport source (
    output valid, mode, map_number, level_number, dynamic_flag, item_index,
    input  ready
  );
  modport sink (
    input  valid, mode, map_number, level_number, dynamic_flag, item_index,
    output ready
  );
endinterface

// File: sv/ffkds_out_if.sv
interface ffkds_out_if import ffkds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              stored;
  logic              dropped_full;
  logic [ECNT_W-1:0] entry_count;

  modport source (
    output valid, hit, stored, dropped_full, entry_count,
    input  ready
  );
  modport sink (
    input  valid, hit, stored, dropped_full, entry_count,
    output ready
  );
endinterface

// File: sv/ffkds_cell.sv
module ffkds_cell import ffkds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   live,
  input  logic   wr_en,
  input  key_t   wr_key,
  input  probe_t probe_in,
  output probe_t probe_out
);

  key_t entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.key <= probe_in.key;
    probe_out.hit <= probe_in.hit | (live & (entry == probe_in.key));
  end

endmodule

// File: sv/four_field_key_dedupe_set_unit.sv
// Bounded set of 49-bit composite keys {map, level, dynamic, item index}.
// Input channel in_ch carries mode and key; output channel out_ch carries
// hit, stored, dropped_full and entry_count, one result per input transfer.
// Keys sit in a row of CAPACITY cells. An insert or query sends a search
// token down the row, one cell per cycle; each held cell compares its key.
// A search passes the token through the CAPACITY cell registers; when it
// leaves the row, the result is set in a pending register and then moved to
// the output register. Clear and the unused mode skip the row. One item is
// in work at a time; the next input transfer is taken once the result has
// moved to the output register.
// An insert of a new key writes the cell at the current count when the
// token leaves the row, unless the set is full.
// Reset empties the set (count 0) and drops any result in flight.
// When the receiver stalls, the result holds in the output register; one
// further item may be taken and finished, then it waits for the register.
module four_field_key_dedupe_set_unit import ffkds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ffkds_in_if.sink     in_ch,
  ffkds_out_if.source  out_ch
);

  state_t  state;
  state_t  state_next;
  mode_t   cur_mode;
  key_t    cur_key;
  count_t  count;
  result_t pend;
  result_t res;
  logic    res_valid;

  logic    in_ready;
  logic    accept;
  logic    is_search;
  logic    start;
  logic    scan_done;
  logic    load;
  logic    is_ins;
  logic    full;
  logic    wr;
  key_t    in_key;

  probe_t  link [0:CAPACITY];

  assign in_key    = {in_ch.map_number, in_ch.level_number, in_ch.dynamic_flag,
                      in_ch.item_index};
  assign accept    = in_ch.valid & in_ready;
  assign is_search = (in_ch.mode == MODE_INSERT) || (in_ch.mode == MODE_QUERY);
  assign is_ins    = (cur_mode == MODE_INSERT);
  assign full      = (count >= CNT_W'(CAPACITY));
  assign wr        = scan_done & is_ins & ~link[CAPACITY].hit & ~full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_search ? S_SCAN : S_HOLD;
        end
      end
      S_SCAN: begin
        if (link[CAPACITY].valid) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!res_valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    scan_done = 1'b0;
    load      = 1'b0;
    case (state)
      S_IDLE: in_ready  = ~rst;
      S_SCAN: scan_done = link[CAPACITY].valid;
      S_HOLD: load      = ~res_valid | out_ch.ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign start = accept & is_search;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_ch.mode == MODE_CLEAR) begin
        count <= '0;
      end else if (wr) begin
        count <= count + 1'b1;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode          <= in_ch.mode;
      cur_key           <= in_key;
      pend.hit          <= 1'b0;
      pend.stored       <= 1'b0;
      pend.dropped_full <= 1'b0;
      pend.entry_count  <= (in_ch.mode == MODE_CLEAR) ? '0 : ECNT_W'(count);
    end else if (scan_done) begin
      pend.hit          <= link[CAPACITY].hit;
      pend.stored       <= wr;
      pend.dropped_full <= is_ins & ~link[CAPACITY].hit & full;
      pend.entry_count  <= wr ? ECNT_W'(count + 1'b1) : ECNT_W'(count);
    end
    if (load) begin
      res <= pend;
    end
  end

  assign link[0].valid = start;
  assign link[0].key   = in_key;
  assign link[0].hit   = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ffkds_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .live      (CNT_W'(i) < count),
      .wr_en     (wr && (count == CNT_W'(i))),
      .wr_key    (cur_key),
      .probe_in  (link[i]),
      .probe_out (link[i+1])
    );
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = res_valid;
  assign out_ch.hit          = res.hit;
  assign out_ch.stored       = res.stored;
  assign out_ch.dropped_full = res.dropped_full;
  assign out_ch.entry_count  = res.entry_count;

endmodule
